[hw/rtl/rgm_pkg.sv]
// ----------------------------------------------------------------------------
// rgm_pkg: shared types and constants of the region grow block
// Command and register codes, compare operations and frontier queue control.
// ----------------------------------------------------------------------------
package rgm_pkg;

    // field widths
    localparam int PIX_W   = 8;
    localparam int CMD_W   = 2;
    localparam int COORD_W = 6;
    localparam int EXT_W   = 7;
    localparam int COUNT_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GROW = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // result kinds
    localparam logic RES_GROW = 1'b0;
    localparam logic RES_READ = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    // register reset values
    localparam logic [PIX_W-1:0] SEED_RESET   = 8'd125;
    localparam logic [PIX_W-1:0] TOL_RESET    = 8'd3;
    localparam logic [EXT_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [EXT_W-1:0] HEIGHT_RESET = 7'd64;

    // operations of the shared compare unit
    typedef enum logic [0:0] {
        CMP_GT   = 1'b0,
        CMP_NEAR = 1'b1
    } cmp_op_t;

    // frontier queue control
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

[hw/rtl/rgm_cmp_unit.sv]
// ----------------------------------------------------------------------------
// rgm_cmp_unit: shared grey level compare unit
// Seed test (value above threshold) or join test (absolute difference within
// tolerance), selected by the sequencer.
// ----------------------------------------------------------------------------
module rgm_cmp_unit (
    input  rgm_pkg::cmp_op_t               op,
    input  logic [rgm_pkg::PIX_W-1:0]      a,
    input  logic [rgm_pkg::PIX_W-1:0]      b,
    input  logic [rgm_pkg::PIX_W-1:0]      limit,
    output logic                           hit
);

    logic [rgm_pkg::PIX_W-1:0] diff;

    // absolute difference
    assign diff = (a > b) ? (a - b) : (b - a);

    // operation select
    always_comb
    begin
        unique case (op)
            rgm_pkg::CMP_GT:   hit = (a > limit);
            rgm_pkg::CMP_NEAR: hit = (diff <= limit);
            default:           hit = 1'b0;
        endcase
    end

endmodule

[hw/rtl/rgm_frontier_fifo.sv]
// ----------------------------------------------------------------------------
// rgm_frontier_fifo: frontier queue of the region grow
// Pixel coordinates in a memory with one write and one registered read port;
// the write pointer doubles as the count of marked pixels.
// ----------------------------------------------------------------------------
module rgm_frontier_fifo #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rgm_pkg::fifo_ctrl_t               ctrl,
    input  logic [DATA_W-1:0]                 push_data,
    output logic [DATA_W-1:0]                 pop_data,
    output logic                              empty,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0]  wr_ptr_reg;
    logic [CNT_W-1:0]  wr_ptr_next;
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  rd_ptr_next;

    // pointer update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (ctrl.clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
        end
        else
        begin
            if (ctrl.push)
                wr_ptr_next = wr_ptr_reg + 1'b1;
            if (ctrl.pop)
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // queue memory, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
            mem[wr_ptr_reg[IDX_W-1:0]] <= push_data;
        pop_data <= mem[rd_ptr_reg[IDX_W-1:0]];
    end

    assign empty = (rd_ptr_reg == wr_ptr_reg);
    assign count = wr_ptr_reg;

endmodule

[hw/rtl/region_grow_mask.sv]
// ----------------------------------------------------------------------------
// region_grow_mask: seeded 4-connected region growing over a grey image
// Image and mask stores, frontier queue and a sequencer around one compare.
// ----------------------------------------------------------------------------
// Usage: a command word is taken when start is high and busy is low.
//   load (0) writes one pixel into the image store; one word per cycle.
//   read (2) returns the mask bit of one pixel with result_strobe in the
//   next cycle (result_kind 1); one word per cycle.
//   grow (1) raises busy, rebuilds the mask and ends with one strobe cycle
//   (result_kind 0) that carries region_count; busy drops the cycle after.
// Grow: a seed sweep over every position of the full store, then for each
//   region pixel a center fetch and a check of each neighbour inside the
//   in-use area (neighbours outside it are skipped), then the done state.
//   One image read port serves the seed sweep, the center fetch and each
//   neighbour check; one compare unit does the seed and join tests.
// Configuration words on cfg_we/cfg_index/cfg_data take effect at once and
//   are to be written only while idle; the block does not enforce this.
// Results cannot be held off; each stands for exactly one cycle.
// Reset: registers return to their defaults, the queue empties, and the
//   mask reads as zero until the first grow; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module region_grow_mask #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rgm_pkg::CMD_W-1:0]         command,
    input  logic [rgm_pkg::COORD_W-1:0]       pixel_row,
    input  logic [rgm_pkg::COORD_W-1:0]       pixel_col,
    input  logic [rgm_pkg::PIX_W-1:0]         pixel_value,
    output logic                              result_strobe,
    output logic                              result_kind,
    output logic                              mask_bit,
    output logic [rgm_pkg::COUNT_W-1:0]       region_count,
    input  logic                              cfg_we,
    input  logic [rgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = $clog2(STORE);
    localparam int CNT_W  = $clog2(STORE + 1);
    localparam int PT_W   = ROW_W + COL_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SCAN     = 9'b000000010,
        ST_SCAN_END = 9'b000000100,
        ST_POP      = 9'b000001000,
        ST_CADDR    = 9'b000010000,
        ST_CVAL     = 9'b000100000,
        ST_NB_ISSUE = 9'b001000000,
        ST_NB_EVAL  = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        addr_of = ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [rgm_pkg::PIX_W-1:0] seed_reg;
    logic [rgm_pkg::PIX_W-1:0] tol_reg;
    logic [rgm_pkg::EXT_W-1:0] width_reg;
    logic [rgm_pkg::EXT_W-1:0] height_reg;
    logic [COL_W:0]            w_eff;
    logic [ROW_W:0]            h_eff;

    // stores
    logic [rgm_pkg::PIX_W-1:0] img_mem [STORE];
    logic                      mask_mem [STORE];
    logic                      img_we;
    logic [ADDR_W-1:0]         img_wa;
    logic [ADDR_W-1:0]         img_ra;
    logic [rgm_pkg::PIX_W-1:0] img_q;
    logic                      mask_we;
    logic [ADDR_W-1:0]         mask_wa;
    logic                      mask_wd;
    logic [ADDR_W-1:0]         mask_ra;
    logic                      mask_q;

    // sweep and grow registers
    logic [ROW_W-1:0]          srow_reg, srow_next;
    logic [COL_W-1:0]          scol_reg, scol_next;
    logic                      s_v_reg, s_v_next;
    logic                      s_in_reg, s_in_next;
    logic [ROW_W-1:0]          s_row_reg, s_row_next;
    logic [COL_W-1:0]          s_col_reg, s_col_next;
    logic [ROW_W-1:0]          p_row_reg, p_row_next;
    logic [COL_W-1:0]          p_col_reg, p_col_next;
    logic [rgm_pkg::PIX_W-1:0] center_reg, center_next;
    logic [ROW_W-1:0]          n_row_reg, n_row_next;
    logic [COL_W-1:0]          n_col_reg, n_col_next;
    logic [1:0]                nb_idx_reg, nb_idx_next;
    logic                      rd_pend_reg, rd_pend_next;
    logic                      rd_ok_reg, rd_ok_next;
    logic                      grown_reg, grown_next;

    // neighbour candidate
    logic [ROW_W-1:0]          nb_row;
    logic [COL_W-1:0]          nb_col;
    logic                      nb_ok;

    // command decode
    logic                      accept;
    logic                      pix_inside;
    logic [ADDR_W-1:0]         pix_addr;
    logic                      scan_last;

    // shared compare and queue
    rgm_pkg::cmp_op_t          cmp_op;
    logic                      cmp_hit;
    rgm_pkg::fifo_ctrl_t       fifo_ctrl;
    logic [PT_W-1:0]           fifo_push_data;
    logic [PT_W-1:0]           fifo_pop_data;
    logic                      fifo_empty;
    logic [CNT_W-1:0]          fifo_count;
    logic [CNT_W+rgm_pkg::COUNT_W-1:0] count_ext;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign pix_inside = (32'(pixel_row) < MAX_HEIGHT) && (32'(pixel_col) < MAX_WIDTH);
    assign pix_addr   = addr_of(ROW_W'(pixel_row), COL_W'(pixel_col));
    assign scan_last  = (srow_reg == ROW_W'(MAX_HEIGHT - 1)) &&
                        (scol_reg == COL_W'(MAX_WIDTH - 1));

    // in-use extent, clamped to 1..max
    always_comb
    begin
        if (width_reg == '0)
            w_eff = (COL_W+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (COL_W+1)'(MAX_WIDTH);
        else
            w_eff = (COL_W+1)'(width_reg);
        if (height_reg == '0)
            h_eff = (ROW_W+1)'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        else
            h_eff = (ROW_W+1)'(height_reg);
    end

    // neighbour order: above, left, right, below
    always_comb
    begin
        nb_row = p_row_reg;
        nb_col = p_col_reg;
        nb_ok  = 1'b0;
        unique case (nb_idx_reg)
            2'd0:
            begin
                nb_row = p_row_reg - 1'b1;
                nb_ok  = (p_row_reg != '0);
            end
            2'd1:
            begin
                nb_col = p_col_reg - 1'b1;
                nb_ok  = (p_col_reg != '0);
            end
            2'd2:
            begin
                nb_col = p_col_reg + 1'b1;
                nb_ok  = (({1'b0, p_col_reg} + 1'b1) < w_eff);
            end
            default:
            begin
                nb_row = p_row_reg + 1'b1;
                nb_ok  = (({1'b0, p_row_reg} + 1'b1) < h_eff);
            end
        endcase
    end

    // shared compare: seed test in the sweep, join test per neighbour
    assign cmp_op = (state_reg == ST_NB_EVAL) ? rgm_pkg::CMP_NEAR : rgm_pkg::CMP_GT;

    rgm_cmp_unit u_cmp (
        .op    (cmp_op),
        .a     (img_q),
        .b     (center_reg),
        .limit ((state_reg == ST_NB_EVAL) ? tol_reg : seed_reg),
        .hit   (cmp_hit)
    );

    // store ports and queue control
    always_comb
    begin
        img_we         = accept && (command == rgm_pkg::CMD_LOAD) && pix_inside;
        img_wa         = pix_addr;
        mask_we        = 1'b0;
        mask_wa        = addr_of(s_row_reg, s_col_reg);
        mask_wd        = s_in_reg && cmp_hit;
        fifo_ctrl      = '0;
        fifo_push_data = {s_row_reg, s_col_reg};

        if (state_reg == ST_CADDR)
            img_ra = addr_of(fifo_pop_data[PT_W-1:COL_W], fifo_pop_data[COL_W-1:0]);
        else if (state_reg == ST_NB_ISSUE)
            img_ra = addr_of(nb_row, nb_col);
        else
            img_ra = addr_of(srow_reg, scol_reg);

        if (state_reg == ST_NB_ISSUE)
            mask_ra = addr_of(nb_row, nb_col);
        else
            mask_ra = pix_addr;

        // seed sweep stage: rewrite every mask bit, queue seeds
        if (s_v_reg)
        begin
            mask_we        = 1'b1;
            fifo_ctrl.push = s_in_reg && cmp_hit;
        end

        // neighbour join
        if (state_reg == ST_NB_EVAL)
        begin
            mask_wa        = addr_of(n_row_reg, n_col_reg);
            mask_wd        = 1'b1;
            mask_we        = !mask_q && cmp_hit;
            fifo_ctrl.push = !mask_q && cmp_hit;
            fifo_push_data = {n_row_reg, n_col_reg};
        end

        fifo_ctrl.clear = accept && (command == rgm_pkg::CMD_GROW);
        fifo_ctrl.pop   = (state_reg == ST_POP) && !fifo_empty;
    end

    // image and mask memories
    always_ff @(posedge clk)
    begin
        if (img_we)
            img_mem[img_wa] <= pixel_value;
        img_q <= img_mem[img_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
            mask_mem[mask_wa] <= mask_wd;
        mask_q <= mask_mem[mask_ra];
    end

    rgm_frontier_fifo #(
        .DEPTH  (STORE),
        .DATA_W (PT_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .push_data (fifo_push_data),
        .pop_data  (fifo_pop_data),
        .empty     (fifo_empty),
        .count     (fifo_count)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        srow_next    = srow_reg;
        scol_next    = scol_reg;
        s_v_next     = 1'b0;
        s_in_next    = (({1'b0, srow_reg}) < h_eff) && (({1'b0, scol_reg}) < w_eff);
        s_row_next   = srow_reg;
        s_col_next   = scol_reg;
        p_row_next   = p_row_reg;
        p_col_next   = p_col_reg;
        center_next  = center_reg;
        n_row_next   = n_row_reg;
        n_col_next   = n_col_reg;
        nb_idx_next  = nb_idx_reg;
        rd_pend_next = 1'b0;
        rd_ok_next   = pix_inside && grown_reg;
        grown_next   = grown_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        rgm_pkg::CMD_GROW:
                        begin
                            srow_next  = '0;
                            scol_next  = '0;
                            grown_next = 1'b1;
                            state_next = ST_SCAN;
                        end
                        rgm_pkg::CMD_READ:
                            rd_pend_next = 1'b1;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                s_v_next = 1'b1;
                if (scol_reg == COL_W'(MAX_WIDTH - 1))
                begin
                    scol_next = '0;
                    srow_next = srow_reg + 1'b1;
                end
                else
                    scol_next = scol_reg + 1'b1;
                if (scan_last)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_END:
                state_next = ST_POP;
            ST_POP:
            begin
                if (fifo_empty)
                    state_next = ST_DONE;
                else
                    state_next = ST_CADDR;
            end
            ST_CADDR:
            begin
                p_row_next = fifo_pop_data[PT_W-1:COL_W];
                p_col_next = fifo_pop_data[COL_W-1:0];
                state_next = ST_CVAL;
            end
            ST_CVAL:
            begin
                center_next = img_q;
                nb_idx_next = 2'd0;
                state_next  = ST_NB_ISSUE;
            end
            ST_NB_ISSUE:
            begin
                if (nb_ok)
                begin
                    n_row_next = nb_row;
                    n_col_next = nb_col;
                    state_next = ST_NB_EVAL;
                end
                else if (nb_idx_reg == 2'd3)
                    state_next = ST_POP;
                else
                    nb_idx_next = nb_idx_reg + 1'b1;
            end
            ST_NB_EVAL:
            begin
                if (nb_idx_reg == 2'd3)
                    state_next = ST_POP;
                else
                begin
                    nb_idx_next = nb_idx_reg + 1'b1;
                    state_next  = ST_NB_ISSUE;
                end
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            s_v_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            grown_reg   <= 1'b0;
            nb_idx_reg  <= 2'd0;
            srow_reg    <= '0;
            scol_reg    <= '0;
            seed_reg    <= rgm_pkg::SEED_RESET;
            tol_reg     <= rgm_pkg::TOL_RESET;
            width_reg   <= rgm_pkg::WIDTH_RESET;
            height_reg  <= rgm_pkg::HEIGHT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            s_v_reg     <= s_v_next;
            rd_pend_reg <= rd_pend_next;
            grown_reg   <= grown_next;
            nb_idx_reg  <= nb_idx_next;
            srow_reg    <= srow_next;
            scol_reg    <= scol_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rgm_pkg::REG_SEED:   seed_reg   <= cfg_data;
                    rgm_pkg::REG_TOL:    tol_reg    <= cfg_data;
                    rgm_pkg::REG_WIDTH:  width_reg  <= cfg_data[rgm_pkg::EXT_W-1:0];
                    rgm_pkg::REG_HEIGHT: height_reg <= cfg_data[rgm_pkg::EXT_W-1:0];
                    default:             seed_reg   <= seed_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s_in_reg   <= s_in_next;
        s_row_reg  <= s_row_next;
        s_col_reg  <= s_col_next;
        p_row_reg  <= p_row_next;
        p_col_reg  <= p_col_next;
        center_reg <= center_next;
        n_row_reg  <= n_row_next;
        n_col_reg  <= n_col_next;
        rd_ok_reg  <= rd_ok_next;
    end

    // result word
    assign count_ext     = {{rgm_pkg::COUNT_W{1'b0}}, fifo_count};
    assign result_strobe = rd_pend_reg || (state_reg == ST_DONE);
    assign result_kind   = rd_pend_reg ? rgm_pkg::RES_READ : rgm_pkg::RES_GROW;
    assign mask_bit      = rd_pend_reg && rd_ok_reg && mask_q;
    assign region_count  = rd_pend_reg ? '0 : count_ext[rgm_pkg::COUNT_W-1:0];

endmodule

[hw/rtl/rgm_checker.sv]
// ----------------------------------------------------------------------------
// rgm_checker: port level checks of the region grow block
// Command to result timing and result word contents, bound to the top level.
// ----------------------------------------------------------------------------
module rgm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [rgm_pkg::CMD_W-1:0]         command,
    input  logic                              result_strobe,
    input  logic                              result_kind,
    input  logic                              mask_bit,
    input  logic [rgm_pkg::COUNT_W-1:0]       region_count
);

    // a read word is answered in the next cycle
    a_read_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == rgm_pkg::CMD_READ)
        |=> result_strobe && (result_kind == rgm_pkg::RES_READ))
        else $error("read word not answered in the next cycle");

    // a grow word holds off the next word
    a_grow_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == rgm_pkg::CMD_GROW) |=> busy)
        else $error("grow word did not raise busy");

    // grow result ends the busy phase
    a_grow_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result_kind == rgm_pkg::RES_GROW) |-> busy ##1 !busy)
        else $error("grow result not at the end of the busy phase");

    // read answers carry no count
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result_kind == rgm_pkg::RES_READ) |-> (region_count == '0))
        else $error("read answer with nonzero count");

    // grow results carry no mask bit
    a_grow_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result_kind == rgm_pkg::RES_GROW) |-> !mask_bit)
        else $error("grow result with mask bit set");

endmodule

bind region_grow_mask rgm_checker u_rgm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .result_strobe (result_strobe),
    .result_kind   (result_kind),
    .mask_bit      (mask_bit),
    .region_count  (region_count)
);

[verif/region_grow_mask_tb.sv]
// ----------------------------------------------------------------------------
// region_grow_mask_tb: self-checking bench for the region grow block
// Loads grey images, runs seed-and-grow commands and reads mask bits under
// several register settings, comparing every result word with a predictor.
// ----------------------------------------------------------------------------
module region_grow_mask_tb;

    localparam int MAX_W         = 64;
    localparam int MAX_H         = 64;
    localparam int STORE_DEPTH   = MAX_W * MAX_H;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 200000;
    localparam int N_PHASES      = 9;
    localparam int PHASE_ITEMS   = 10;

    // the block has no use for this code and must drop it
    localparam logic [rgm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        PAINT_FLAT,
        PAINT_RAMP,
        PAINT_NOISE,
        PAINT_CHECKER
    } paint_style_t;

    typedef struct {
        logic [rgm_pkg::CMD_W-1:0]   cmd;
        logic [rgm_pkg::COORD_W-1:0] row;
        logic [rgm_pkg::COORD_W-1:0] col;
        logic [rgm_pkg::PIX_W-1:0]   value;
        bit                          hold;
    } pix_word_t;

    typedef struct {
        logic                        kind;
        logic                        bit_val;
        logic [rgm_pkg::COUNT_W-1:0] count;
    } mask_answer_t;

    // register settings per phase: seed, tolerance, width, height, sender idling
    int unsigned phase_seed [N_PHASES] = '{125, 0, 255, 100, 128, 60, 90, 140, 125};
    int unsigned phase_tol  [N_PHASES] = '{3, 0, 255, 10, 1, 20, 5, 4, 3};
    int unsigned phase_wide [N_PHASES] = '{6, 1, 5, 0, 16, 127, 2, 10, 12};
    int unsigned phase_tall [N_PHASES] = '{6, 1, 7, 6, 3, 1, 197, 6, 5};
    int unsigned phase_idle [N_PHASES] = '{0, 0, 72, 72, 0, 0, 22, 22, 0};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [rgm_pkg::CMD_W-1:0]      command = rgm_pkg::CMD_LOAD;
    logic [rgm_pkg::COORD_W-1:0]    pixel_row = '0;
    logic [rgm_pkg::COORD_W-1:0]    pixel_col = '0;
    logic [rgm_pkg::PIX_W-1:0]      pixel_value = '0;
    logic                           result_strobe;
    logic                           result_kind;
    logic                           mask_bit;
    logic [rgm_pkg::COUNT_W-1:0]    region_count;
    logic                           cfg_we = 1'b0;
    logic [rgm_pkg::CFG_IDX_W-1:0]  cfg_index = rgm_pkg::REG_SEED;
    logic [rgm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic [rgm_pkg::PIX_W-1:0] image_ref [0:STORE_DEPTH-1];
    bit                        mask_ref [0:STORE_DEPTH-1];
    int unsigned               frontier_ref [$];
    int unsigned               marked_ref = 0;
    logic [rgm_pkg::PIX_W-1:0] seed_thr_ref = rgm_pkg::SEED_RESET;
    logic [rgm_pkg::PIX_W-1:0] tol_ref = rgm_pkg::TOL_RESET;
    logic [rgm_pkg::EXT_W-1:0] width_ref = rgm_pkg::WIDTH_RESET;
    logic [rgm_pkg::EXT_W-1:0] height_ref = rgm_pkg::HEIGHT_RESET;

    pix_word_t    pending_q [$];
    mask_answer_t answer_q [$];
    pix_word_t    next_word;
    mask_answer_t oldest;
    int unsigned  send_idle_pct = 0;
    int unsigned  items_queued = 0;
    int unsigned  err_count = 0;
    int unsigned  stall_cycles = 0;

    region_grow_mask #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .pixel_value   (pixel_value),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .mask_bit      (mask_bit),
        .region_count  (region_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // zero extent counts as one, oversize as the maximum extent
    function automatic int unsigned eff_extent(input logic [rgm_pkg::EXT_W-1:0] v,
                                               input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void mark_px(input int unsigned addr);
        mask_ref[addr] = 1'b1;
        marked_ref++;
        frontier_ref.insert(frontier_ref.size(), addr);
    endfunction

    // neighbor joins when in the area, unmarked and close enough in grey level
    function automatic void try_join(input int unsigned from, input int r, input int c,
                                     input int unsigned w, input int unsigned h);
        int unsigned addr;
        int diff;
        if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w))
            return;
        addr = r * MAX_W + c;
        if (mask_ref[addr])
            return;
        diff = int'(image_ref[addr]) - int'(image_ref[from]);
        if (diff < 0)
            diff = -diff;
        if (diff > int'(tol_ref))
            return;
        mark_px(addr);
    endfunction

    function automatic int unsigned grow_region();
        int unsigned w;
        int unsigned h;
        int unsigned p;
        int pr;
        int pc;
        w = eff_extent(width_ref, MAX_W);
        h = eff_extent(height_ref, MAX_H);
        foreach (mask_ref[i])
            mask_ref[i] = 1'b0;
        frontier_ref.delete();
        marked_ref = 0;
        // seeds in raster order
        for (int r = 0; r < int'(h); r++)
            for (int c = 0; c < int'(w); c++)
                if (image_ref[r * MAX_W + c] > seed_thr_ref)
                    mark_px(r * MAX_W + c);
        // breadth-first growth: above, left, right, below
        while (frontier_ref.size() != 0)
        begin
            p = frontier_ref.pop_front();
            pr = p / MAX_W;
            pc = p % MAX_W;
            try_join(p, pr - 1, pc, w, h);
            try_join(p, pr, pc - 1, w, h);
            try_join(p, pr, pc + 1, w, h);
            try_join(p, pr + 1, pc, w, h);
        end
        return marked_ref;
    endfunction

    task automatic apply_command(input logic [rgm_pkg::CMD_W-1:0] cmd,
                                 input logic [rgm_pkg::COORD_W-1:0] row,
                                 input logic [rgm_pkg::COORD_W-1:0] col,
                                 input logic [rgm_pkg::PIX_W-1:0] value);
        mask_answer_t ans;
        int unsigned addr;
        addr = row * MAX_W + col;
        case (cmd)
            rgm_pkg::CMD_LOAD:
                image_ref[addr] = value;
            rgm_pkg::CMD_GROW:
            begin
                ans.kind = rgm_pkg::RES_GROW;
                ans.bit_val = 1'b0;
                ans.count = rgm_pkg::COUNT_W'(grow_region());
                answer_q.insert(answer_q.size(), ans);
            end
            rgm_pkg::CMD_READ:
            begin
                ans.kind = rgm_pkg::RES_READ;
                ans.bit_val = mask_ref[addr];
                ans.count = '0;
                answer_q.insert(answer_q.size(), ans);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // driver: one command word per handshake, with random idle cycles
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                apply_command(command, pixel_row, pixel_col, pixel_value);
            if (!start || !busy)
            begin
                // a held word waits for every pending result
                if (pending_q.size() != 0 && !(pending_q[0].hold && answer_q.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = pending_q.pop_front();
                    start <= 1'b1;
                    command <= next_word.cmd;
                    pixel_row <= next_word.row;
                    pixel_col <= next_word.col;
                    pixel_value <= next_word.value;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d (t=%0t)", field, got, want, $time);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (answer_q.size() == 0)
            begin
                report_mismatch("unexpected result word, kind", result_kind, -1);
            end
            else
            begin
                oldest = answer_q.pop_front();
                if (result_kind !== oldest.kind)
                    report_mismatch("result_kind", result_kind, oldest.kind);
                if (mask_bit !== oldest.bit_val)
                    report_mismatch("mask_bit", mask_bit, oldest.bit_val);
                if (region_count !== oldest.count)
                    report_mismatch("region_count", region_count, oldest.count);
            end
        end
    end

    // watchdog: cycles with no word taken and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("[region_grow_mask] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic [rgm_pkg::CMD_W-1:0] cmd, input int unsigned row,
                              input int unsigned col, input int unsigned value,
                              input bit hold);
        pix_word_t wd;
        wd.cmd = cmd;
        wd.row = rgm_pkg::COORD_W'(row);
        wd.col = rgm_pkg::COORD_W'(col);
        wd.value = rgm_pkg::PIX_W'(value);
        wd.hold = hold;
        pending_q.insert(pending_q.size(), wd);
        items_queued++;
    endtask

    // block idle: queue drained, no result pending, then let loads finish
    task automatic settle_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || start || busy || answer_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rgm_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= rgm_pkg::CFG_DATA_W'(data);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rgm_pkg::REG_SEED:   seed_thr_ref = rgm_pkg::PIX_W'(data);
            rgm_pkg::REG_TOL:    tol_ref = rgm_pkg::PIX_W'(data);
            rgm_pkg::REG_WIDTH:  width_ref = rgm_pkg::EXT_W'(data);
            rgm_pkg::REG_HEIGHT: height_ref = rgm_pkg::EXT_W'(data);
            default: ;
        endcase
    endtask

    // grey level around the seed threshold
    function automatic logic [rgm_pkg::PIX_W-1:0] base_level();
        return rgm_pkg::PIX_W'(int'(seed_thr_ref) + $urandom_range(0, 4) - 2);
    endfunction

    function automatic logic [rgm_pkg::PIX_W-1:0] near_value(
        input logic [rgm_pkg::PIX_W-1:0] base);
        return rgm_pkg::PIX_W'(base + $urandom_range(0, tol_ref + 1));
    endfunction

    // load every pixel of the in-use area
    task automatic paint_area(input paint_style_t style);
        int unsigned w;
        int unsigned h;
        int unsigned step;
        logic [rgm_pkg::PIX_W-1:0] base;
        logic [rgm_pkg::PIX_W-1:0] v;
        w = eff_extent(width_ref, MAX_W);
        h = eff_extent(height_ref, MAX_H);
        base = base_level();
        step = $urandom_range(0, 3);
        for (int r = 0; r < int'(h); r++)
            for (int c = 0; c < int'(w); c++)
            begin
                case (style)
                    PAINT_FLAT:  v = near_value(base);
                    PAINT_RAMP:  v = rgm_pkg::PIX_W'(base + r * step + c * step);
                    PAINT_NOISE: v = rgm_pkg::PIX_W'($urandom_range(0, 255));
                    default:     v = ((r / 2 + c / 2) % 2 != 0) ? base : ~base;
                endcase
                queue_word(rgm_pkg::CMD_LOAD, r, c, v, 1'b0);
            end
    endtask

    // stray word anywhere in the store
    task automatic queue_noise();
        case ($urandom_range(0, 2))
            0: queue_word(rgm_pkg::CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255), 1'b0);
            1: queue_word(rgm_pkg::CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255), 1'b0);
            default: queue_word(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                $urandom_range(0, 255), 1'b0);
        endcase
    endtask

    // touch up the image, grow, then probe the mask
    task automatic run_episode();
        int unsigned w;
        int unsigned h;
        logic [rgm_pkg::PIX_W-1:0] base;
        w = eff_extent(width_ref, MAX_W);
        h = eff_extent(height_ref, MAX_H);
        base = base_level();
        repeat ($urandom_range(1, 4))
            queue_word(rgm_pkg::CMD_LOAD, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                       near_value(base), 1'b0);
        repeat ($urandom_range(0, 2))
            queue_noise();
        queue_word(rgm_pkg::CMD_GROW, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 255), $urandom_range(0, 1));
        repeat ($urandom_range(3, 6))
        begin
            if ($urandom_range(0, 3) != 0)
                queue_word(rgm_pkg::CMD_READ, $urandom_range(0, h - 1),
                           $urandom_range(0, w - 1), $urandom_range(0, 255), 1'b0);
            else
                queue_word(rgm_pkg::CMD_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 255), 1'b0);
        end
        repeat ($urandom_range(0, 2))
            queue_noise();
    endtask

    initial
    begin : stimulus
        int unsigned phase_base;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // mask is clear out of reset; unused command is dropped
        queue_word(rgm_pkg::CMD_READ, 0, 0, 0, 1'b0);
        queue_word(rgm_pkg::CMD_READ, 63, 63, 255, 1'b0);
        queue_word(rgm_pkg::CMD_READ, 31, 32, 0, 1'b0);
        queue_word(CMD_UNUSED, 63, 63, 255, 1'b0);
        settle_idle();

        // 3x3 image: tolerance edge at differences of 3 and 4, grey extremes
        write_reg(rgm_pkg::REG_SEED, 199);
        write_reg(rgm_pkg::REG_TOL, 3);
        write_reg(rgm_pkg::REG_WIDTH, 3);
        write_reg(rgm_pkg::REG_HEIGHT, 3);
        queue_word(rgm_pkg::CMD_LOAD, 0, 0, 0, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 0, 1, 197, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 0, 2, 10, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 1, 0, 196, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 1, 1, 200, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 1, 2, 203, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 2, 0, 10, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 2, 1, 206, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 2, 2, 255, 1'b0);
        // loads outside the in-use area are stored but not grown
        queue_word(rgm_pkg::CMD_LOAD, 63, 63, 255, 1'b0);
        queue_word(rgm_pkg::CMD_LOAD, 0, 63, 128, 1'b0);
        queue_word(rgm_pkg::CMD_GROW, 0, 0, 0, 1'b1);
        queue_word(rgm_pkg::CMD_READ, 1, 1, 0, 1'b0);
        queue_word(rgm_pkg::CMD_READ, 1, 0, 0, 1'b0);
        queue_word(rgm_pkg::CMD_READ, 63, 63, 0, 1'b0);
        queue_word(rgm_pkg::CMD_READ, 0, 1, 0, 1'b0);

        // random phases over register settings and idling
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle_idle();
            send_idle_pct = phase_idle[ph];
            write_reg(rgm_pkg::REG_SEED, phase_seed[ph]);
            write_reg(rgm_pkg::REG_TOL, phase_tol[ph]);
            write_reg(rgm_pkg::REG_WIDTH, phase_wide[ph]);
            write_reg(rgm_pkg::REG_HEIGHT, phase_tall[ph]);
            if (ph == N_PHASES - 1)
                paint_area(PAINT_RAMP);
            else
                paint_area(paint_style_t'($urandom_range(0, 3)));
            phase_base = items_queued;
            while (items_queued - phase_base < PHASE_ITEMS)
                run_episode();
        end

        settle_idle();
        if (answer_q.size() != 0)
            report_mismatch("results never received", answer_q.size(), 0);
        if (err_count == 0)
            $display("[region_grow_mask] OK");
        else
            $display("[region_grow_mask] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/rgm_pkg.sv
hw/rtl/rgm_cmp_unit.sv
hw/rtl/rgm_frontier_fifo.sv
hw/rtl/region_grow_mask.sv
hw/rtl/rgm_checker.sv
verif/region_grow_mask_tb.sv
